[src/infix_expression_evaluator_macros.svh]
// Assertion macros used by the evaluator's top-level RTL file.
// No dependencies.
`ifndef INFIX_EXPRESSION_EVALUATOR_MACROS_SVH
`define INFIX_EXPRESSION_EVALUATOR_MACROS_SVH
// implication checked at every clock, reset disables
`define IEE_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// next-cycle implication
`define IEE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

[src/iee_pkg.sv]
// Types and constants of the infix expression evaluator.
// No dependencies.
package iee_pkg;
   localparam logic [2:0] KIND_NUMBER = 3'd0;
   localparam logic [2:0] KIND_OPERATOR = 3'd1;
   localparam logic [2:0] KIND_LPAREN = 3'd2;
   localparam logic [2:0] KIND_RPAREN = 3'd3;
   localparam logic [2:0] KIND_END = 3'd4;

   localparam logic [2:0] OP_ADD = 3'd0;
   localparam logic [2:0] OP_SUB = 3'd1;
   localparam logic [2:0] OP_MUL = 3'd2;
   localparam logic [2:0] OP_DIV = 3'd3;
   localparam logic [2:0] OP_LPAREN = 3'd4;

   localparam logic [2:0] ST_OK = 3'd0;
   localparam logic [2:0] ST_MALFORMED = 3'd1;
   localparam logic [2:0] ST_OVERFLOW = 3'd2;
   localparam logic [2:0] ST_DIVZERO = 3'd3;
   localparam logic [2:0] ST_SATURATED = 3'd4;

   typedef struct packed {
      logic [2:0] token_kind;
      logic [1:0] operator_code;
      logic [30:0] number_value;
   } req_type;

   typedef struct packed {
      logic signed [31:0] result_value;
      logic [2:0] status;
   } rsp_type;

   // divider control
   typedef struct packed {
      logic start;
      logic [63:0] dividend;
      logic [31:0] divisor;
   } div_cmd_type;

   typedef struct packed {
      logic done;
      logic [63:0] quotient;
   } div_res_type;
endpackage

[src/iee_if.sv]
// Valid/ready channel interface carrying a payload type.
// No dependencies; the payload type is a parameter.
interface iee_if #(parameter type payload_type = logic) (input logic clock);
   logic valid;
   logic ready;
   payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

[src/iee_divider.sv]
// Radix-2 restoring divider of a 64-bit magnitude by a 32-bit magnitude.
// Depends on iee_pkg.
module iee_divider (
   input logic clock,
   input logic reset,
   input iee_pkg::div_cmd_type cmd,
   output iee_pkg::div_res_type res
);
   logic [63:0] quot_ff, quot_in;
   logic [31:0] rem_ff, rem_in;
   logic [31:0] dvs_ff, dvs_in;
   logic [6:0] count_ff, count_in;
   logic busy_ff, busy_in;
   logic done_ff, done_in;
   logic [32:0] trial;

   always_comb begin
      quot_in = quot_ff;
      rem_in = rem_ff;
      dvs_in = dvs_ff;
      count_in = count_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial = {rem_ff, quot_ff[63]} - {1'b0, dvs_ff};
      if (cmd.start) begin
         quot_in = cmd.dividend;
         rem_in = '0;
         dvs_in = cmd.divisor;
         count_in = 7'd0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // shift in one dividend bit, keep the difference when it fits
         // (the divisor never exceeds 2^31, so the remainder fits 32 bits)
         if (!trial[32]) begin
            rem_in = trial[31:0];
            quot_in = {quot_ff[62:0], 1'b1};
         end else begin
            rem_in = {rem_ff[30:0], quot_ff[63]};
            quot_in = {quot_ff[62:0], 1'b0};
         end
         count_in = count_ff + 7'd1;
         if (count_ff == 7'd63) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         count_ff <= count_in;
      end
      quot_ff <= quot_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign res.done = done_ff;
   assign res.quotient = quot_ff;
endmodule

[src/infix_expression_evaluator.sv]
// Top level of the infix expression evaluator.
// Depends on iee_pkg, iee_if, iee_divider and the macros header.
//
//   channel  direction  payload                                   handshake
//   req      in         token_kind, operator_code, number_value   valid/ready
//   rsp      out        result_value, status                      valid/ready
//
// A number, left parenthesis or ignored token passes through dispatch only; an operator
// or right parenthesis also reads and decides on the top operator, and an end token then
// reads the result and emits it; each reduction reads operands and operator, computes and
// writes back. A multiply also passes through the wait state, a division waits there on the radix-2 divider.
// Reset clears the stack pointers, error status and output valid; memories stay undefined.
// A result waits in the output register; later tokens are taken, a second end token holds.
`include "infix_expression_evaluator_macros.svh"
module infix_expression_evaluator #(
   parameter int STACK_DEPTH = 16,
   parameter int FRACTION_BITS = 16
) (
   input logic clock,
   input logic reset,
   iee_if.sink req,
   iee_if.source rsp
);
   localparam int PW = $clog2(STACK_DEPTH);
   localparam int CW = $clog2(STACK_DEPTH + 1);
   localparam logic [CW-1:0] FULL = CW'(STACK_DEPTH);

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_DISPATCH = 4'd1;
   localparam logic [3:0] S_PEEK = 4'd2;
   localparam logic [3:0] S_DECIDE = 4'd3;
   localparam logic [3:0] S_RD_LHS = 4'd4;
   localparam logic [3:0] S_CALC = 4'd5;
   localparam logic [3:0] S_DIVWAIT = 4'd6;
   localparam logic [3:0] S_MULT = 4'd7;
   localparam logic [3:0] S_FINISH = 4'd8;
   localparam logic [3:0] S_RD_RESULT = 4'd9;
   localparam logic [3:0] S_EMIT = 4'd10;

   // stack memories, one synchronous read port each
   logic [31:0] vmem [STACK_DEPTH];
   logic [2:0] omem [STACK_DEPTH];
   logic [31:0] vrd_ff;
   logic [2:0] ord_ff;
   logic [PW-1:0] vra, ora, vwa, owa;
   logic vwe, owe;
   logic [31:0] vwd;
   logic [2:0] owd;

   logic [3:0] state_ff, state_in;
   logic [CW-1:0] vtop_ff, vtop_in, otop_ff, otop_in;
   logic [2:0] err_ff, err_in;
   iee_pkg::req_type tok_ff, tok_in;
   logic signed [31:0] rhs_ff, rhs_in, lhs_ff, lhs_in;
   logic [2:0] op_ff, op_in;
   logic [63:0] prod_ff, prod_in;
   logic [31:0] res_ff, res_in;
   logic rsp_valid_ff, rsp_valid_in;
   iee_pkg::rsp_type rsp_ff, rsp_in;
   iee_pkg::div_cmd_type dcmd;
   iee_pkg::div_res_type dres;

   logic hard;
   logic [31:0] mag_l, mag_r;
   logic neg;
   logic signed [32:0] sum;
   logic [1:0] rank_top, rank_code;

   function automatic logic [2:0] flag_err(input logic [2:0] cur, input logic [2:0] code);
      flag_err = (cur == iee_pkg::ST_MALFORMED || cur == iee_pkg::ST_OVERFLOW ||
                  cur == iee_pkg::ST_DIVZERO) ? cur : code;
   endfunction

   function automatic logic [1:0] rank_of(input logic [2:0] op);
      case (op)
         iee_pkg::OP_MUL, iee_pkg::OP_DIV: rank_of = 2'd2;
         iee_pkg::OP_ADD, iee_pkg::OP_SUB: rank_of = 2'd1;
         default: rank_of = 2'd0;
      endcase
   endfunction

   // saturate a magnitude with sign applied
   function automatic logic [32:0] sclamp(input logic [63:0] mag, input logic n);
      logic [32:0] r;
      if (n) begin
         if (mag > 64'h8000_0000) r = {1'b1, 32'h8000_0000};
         else r = {1'b0, 32'(-mag)};
      end else begin
         if (mag > 64'h7FFF_FFFF) r = {1'b1, 32'h7FFF_FFFF};
         else r = {1'b0, mag[31:0]};
      end
      sclamp = r;
   endfunction

   iee_divider u_div (.clock(clock), .reset(reset), .cmd(dcmd), .res(dres));

   always_ff @(posedge clock) begin
      if (vwe) vmem[vwa] <= vwd;
      if (owe) omem[owa] <= owd;
      vrd_ff <= vmem[vra];
      ord_ff <= omem[ora];
   end

   assign hard = err_ff == iee_pkg::ST_MALFORMED || err_ff == iee_pkg::ST_OVERFLOW ||
                 err_ff == iee_pkg::ST_DIVZERO;
   assign mag_l = lhs_ff[31] ? 32'(-lhs_ff) : 32'(lhs_ff);
   assign mag_r = rhs_ff[31] ? 32'(-rhs_ff) : 32'(rhs_ff);
   assign neg = lhs_ff[31] != rhs_ff[31];
   assign rank_top = rank_of(ord_ff);
   assign rank_code = rank_of({1'b0, tok_ff.operator_code});
   assign req.ready = state_ff == S_IDLE;
   assign rsp.valid = rsp_valid_ff;
   assign rsp.payload = rsp_ff;

   always_comb begin
      logic [32:0] c;
      state_in = state_ff;
      vtop_in = vtop_ff;
      otop_in = otop_ff;
      err_in = err_ff;
      tok_in = tok_ff;
      rhs_in = rhs_ff;
      lhs_in = lhs_ff;
      op_in = op_ff;
      prod_in = prod_ff;
      res_in = res_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in = rsp_ff;
      vra = PW'(vtop_ff - CW'(1));
      ora = PW'(otop_ff - CW'(1));
      vwe = 1'b0;
      owe = 1'b0;
      vwa = PW'(vtop_ff);
      owa = PW'(otop_ff);
      vwd = {1'b0, tok_ff.number_value};
      owd = iee_pkg::OP_LPAREN;
      dcmd = '0;
      c = '0;
      if (rsp_valid_ff && rsp.ready) rsp_valid_in = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req.valid) begin
               tok_in = req.payload;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            // push a number or left parenthesis; operators, right parentheses and end go to the top-operator read
            state_in = S_IDLE;
            if (tok_ff.token_kind == iee_pkg::KIND_END) state_in = S_PEEK;
            else if (!hard) begin
               case (tok_ff.token_kind)
                  iee_pkg::KIND_NUMBER: begin
                     if (vtop_ff >= FULL) err_in = flag_err(err_ff, iee_pkg::ST_OVERFLOW);
                     else begin
                        vwe = 1'b1;
                        vtop_in = vtop_ff + CW'(1);
                     end
                  end
                  iee_pkg::KIND_LPAREN: begin
                     if (otop_ff >= FULL) err_in = flag_err(err_ff, iee_pkg::ST_OVERFLOW);
                     else begin
                        owe = 1'b1;
                        otop_in = otop_ff + CW'(1);
                     end
                  end
                  iee_pkg::KIND_OPERATOR, iee_pkg::KIND_RPAREN: state_in = S_PEEK;
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_PEEK: begin
            // top operator address issued, data next cycle
            state_in = S_DECIDE;
         end
         S_DECIDE: begin
            state_in = S_IDLE;
            case (tok_ff.token_kind)
               iee_pkg::KIND_END: begin
                  if (hard) state_in = S_EMIT;
                  else if (otop_ff == '0) state_in = S_RD_RESULT;
                  else if (ord_ff == iee_pkg::OP_LPAREN) begin
                     err_in = flag_err(err_ff, iee_pkg::ST_MALFORMED);
                     state_in = S_EMIT;
                  end else state_in = S_RD_LHS;
               end
               iee_pkg::KIND_OPERATOR: begin
                  if (otop_ff != '0 && ord_ff != iee_pkg::OP_LPAREN && rank_top >= rank_code)
                     state_in = S_RD_LHS;
                  else if (otop_ff >= FULL) err_in = flag_err(err_ff, iee_pkg::ST_OVERFLOW);
                  else begin
                     owe = 1'b1;
                     owd = {1'b0, tok_ff.operator_code};
                     otop_in = otop_ff + CW'(1);
                  end
               end
               default: begin
                  if (otop_ff == '0) err_in = flag_err(err_ff, iee_pkg::ST_MALFORMED);
                  else if (ord_ff == iee_pkg::OP_LPAREN) otop_in = otop_ff - CW'(1);
                  else state_in = S_RD_LHS;
               end
            endcase
            // value top read issued here for the right operand
            op_in = ord_ff;
         end
         S_RD_LHS: begin
            if (vtop_ff < CW'(2)) begin
               err_in = flag_err(err_ff, iee_pkg::ST_MALFORMED);
               state_in = tok_ff.token_kind == iee_pkg::KIND_END ? S_EMIT : S_IDLE;
            end else begin
               rhs_in = vrd_ff;
               vra = PW'(vtop_ff - CW'(2));
               otop_in = otop_ff - CW'(1);
               state_in = S_CALC;
            end
         end
         S_CALC: begin
            lhs_in = vrd_ff;
            state_in = S_MULT;
         end
         S_MULT: begin
            // operands registered: start the operation
            state_in = S_FINISH;
            case (op_ff)
               iee_pkg::OP_ADD: begin
                  sum = 33'(lhs_ff) + 33'(rhs_ff);
                  if (sum[32] != sum[31]) begin
                     res_in = sum[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
                     if (err_ff == iee_pkg::ST_OK) err_in = iee_pkg::ST_SATURATED;
                  end else res_in = sum[31:0];
               end
               iee_pkg::OP_SUB: begin
                  sum = 33'(lhs_ff) - 33'(rhs_ff);
                  if (sum[32] != sum[31]) begin
                     res_in = sum[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
                     if (err_ff == iee_pkg::ST_OK) err_in = iee_pkg::ST_SATURATED;
                  end else res_in = sum[31:0];
               end
               iee_pkg::OP_MUL: begin
                  prod_in = 64'(mag_l) * 64'(mag_r);
                  state_in = S_DIVWAIT;
               end
               default: begin
                  if (rhs_ff == '0) begin
                     err_in = flag_err(err_ff, iee_pkg::ST_DIVZERO);
                     state_in = tok_ff.token_kind == iee_pkg::KIND_END ? S_EMIT : S_IDLE;
                  end else begin
                     dcmd.start = 1'b1;
                     dcmd.dividend = 64'(mag_l) << FRACTION_BITS;
                     dcmd.divisor = mag_r;
                     state_in = S_DIVWAIT;
                  end
               end
            endcase
            if (op_ff != iee_pkg::OP_ADD && op_ff != iee_pkg::OP_SUB) sum = '0;
         end
         S_DIVWAIT: begin
            if (op_ff == iee_pkg::OP_MUL) c = sclamp(prod_ff >> FRACTION_BITS, neg);
            else c = sclamp(dres.quotient, neg);
            if (op_ff == iee_pkg::OP_MUL || dres.done) begin
               res_in = c[31:0];
               if (c[32] && err_ff == iee_pkg::ST_OK) err_in = iee_pkg::ST_SATURATED;
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            // write back over the left operand, drop the right one
            vwe = 1'b1;
            vwa = PW'(vtop_ff - CW'(2));
            vwd = res_ff;
            vtop_in = vtop_ff - CW'(1);
            state_in = S_PEEK;
         end
         S_RD_RESULT: begin
            vra = '0;
            if (vtop_ff != CW'(1)) begin
               err_in = flag_err(err_ff, iee_pkg::ST_MALFORMED);
               state_in = S_EMIT;
            end else begin
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            // wait for the output register to be free
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in = 1'b1;
               rsp_in.status = err_ff;
               rsp_in.result_value = hard ? '0 : vrd_ff;
               vtop_in = '0;
               otop_in = '0;
               err_in = iee_pkg::ST_OK;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
      if (state_ff != S_MULT) sum = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         vtop_ff <= '0;
         otop_ff <= '0;
         err_ff <= iee_pkg::ST_OK;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         vtop_ff <= vtop_in;
         otop_ff <= otop_in;
         err_ff <= err_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      tok_ff <= tok_in;
      rhs_ff <= rhs_in;
      lhs_ff <= lhs_in;
      op_ff <= op_in;
      prod_ff <= prod_in;
      res_ff <= res_in;
      rsp_ff <= rsp_in;
   end

   `IEE_ASSERT_IMPL(a_vtop_range, clock, reset, 1'b1, vtop_ff <= FULL, "value stack overrun")
   `IEE_ASSERT_IMPL(a_otop_range, clock, reset, 1'b1, otop_ff <= FULL, "operator stack overrun")
   `IEE_ASSERT_NEXT(a_emit_clears, clock, reset, state_ff == S_EMIT && state_in == S_IDLE, rsp_valid_ff && vtop_ff == '0 && err_ff == iee_pkg::ST_OK, "end transaction did not clear stacks")
endmodule

[sim/infix_expression_evaluator_tb.sv]
// Self-checking testbench for the infix expression evaluator: token stream in, value out.
// Depends on iee_pkg, iee_if and the infix_expression_evaluator RTL.
module infix_expression_evaluator_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int STACK_N = 16;
   localparam int FRAC = 16;
   localparam longint CYCLE_LIMIT = 3000000;
   localparam int TOKEN_BUDGET = 700;
   localparam int HOLD_AT = 120;
   localparam int HOLD_CYCLES = 500;

   // Golden evaluator: two stacks plus the error status of the expression; a hard error replaces a saturation.
   class expr_scoreboard;
      logic signed [31:0] vals[STACK_N];
      int unsigned vtop;
      logic [2:0] ops[STACK_N];
      int unsigned otop;
      logic [2:0] err;
      iee_pkg::rsp_type pending[$];
      int unsigned failures;

      function void clear();
         vtop = 0;
         otop = 0;
         err = iee_pkg::ST_OK;
      endfunction

      function bit hard();
         return err >= iee_pkg::ST_MALFORMED && err <= iee_pkg::ST_DIVZERO;
      endfunction

      function void raise_err(logic [2:0] code);
         if (!hard()) err = code;
      endfunction

      function void note_sat();
         if (err == iee_pkg::ST_OK) err = iee_pkg::ST_SATURATED;
      endfunction

      function logic signed [31:0] clamp(longint v);
         if (v > 64'sd2147483647) begin
            note_sat();
            return 32'sh7FFFFFFF;
         end
         if (v < -64'sd2147483648) begin
            note_sat();
            return 32'sh80000000;
         end
         return v[31:0];
      endfunction

      function longint unsigned mag(logic signed [31:0] v);
         longint w;
         w = v;
         return (w < 0) ? -w : w;
      endfunction

      function logic signed [31:0] sign_clamp(longint unsigned m, bit neg);
         longint w;
         if (neg) begin
            if (m > 64'h80000000) begin
               note_sat();
               return 32'sh80000000;
            end
            w = -longint'(m);
            return w[31:0];
         end
         if (m > 64'h7FFFFFFF) begin
            note_sat();
            return 32'sh7FFFFFFF;
         end
         return m[31:0];
      endfunction

      function int rank(logic [2:0] op);
         if (op == iee_pkg::OP_MUL || op == iee_pkg::OP_DIV) return 2;
         if (op == iee_pkg::OP_ADD || op == iee_pkg::OP_SUB) return 1;
         return 0;
      endfunction

      // Pop two values and one operator, push the outcome; 0 on a hard error.
      function bit reduce();
         logic signed [31:0] lhs, rhs, res;
         logic [2:0] op;
         bit neg;
         if (vtop < 2 || otop == 0) begin
            raise_err(iee_pkg::ST_MALFORMED);
            return 0;
         end
         rhs = vals[vtop-1];
         lhs = vals[vtop-2];
         otop--;
         op = ops[otop];
         neg = (lhs < 0) != (rhs < 0);
         case (op)
            iee_pkg::OP_ADD: res = clamp(longint'(lhs) + longint'(rhs));
            iee_pkg::OP_SUB: res = clamp(longint'(lhs) - longint'(rhs));
            iee_pkg::OP_MUL: res = sign_clamp((mag(lhs) * mag(rhs)) >> FRAC, neg);
            iee_pkg::OP_DIV: begin
               if (rhs == 0) begin
                  raise_err(iee_pkg::ST_DIVZERO);
                  return 0;
               end
               res = sign_clamp((mag(lhs) << FRAC) / mag(rhs), neg);
            end
            default: begin
               raise_err(iee_pkg::ST_MALFORMED);
               return 0;
            end
         endcase
         vtop--;
         vals[vtop-1] = res;
         return 1;
      endfunction

      function void push_op(logic [2:0] op);
         if (otop >= STACK_N) raise_err(iee_pkg::ST_OVERFLOW);
         else begin
            ops[otop] = op;
            otop++;
         end
      endfunction

      // Advance the golden state by one accepted token.
      function void note_token(iee_pkg::req_type t);
         iee_pkg::rsp_type r;
         if (t.token_kind == iee_pkg::KIND_END) begin
            while (!hard() && otop != 0) begin
               if (ops[otop-1] == iee_pkg::OP_LPAREN) begin
                  raise_err(iee_pkg::ST_MALFORMED);
                  break;
               end
               if (!reduce()) break;
            end
            if (!hard() && vtop != 1) raise_err(iee_pkg::ST_MALFORMED);
            r.status = err;
            r.result_value = hard() ? 32'sd0 : vals[0];
            pending.push_back(r);
            clear();
            return;
         end
         if (hard()) return;
         case (t.token_kind)
            iee_pkg::KIND_NUMBER: begin
               if (vtop >= STACK_N) raise_err(iee_pkg::ST_OVERFLOW);
               else begin
                  vals[vtop] = {1'b0, t.number_value};
                  vtop++;
               end
            end
            iee_pkg::KIND_OPERATOR: begin
               while (otop != 0 && ops[otop-1] != iee_pkg::OP_LPAREN &&
                      rank(ops[otop-1]) >= rank({1'b0, t.operator_code}))
                  if (!reduce()) return;
               push_op({1'b0, t.operator_code});
            end
            iee_pkg::KIND_LPAREN: push_op(iee_pkg::OP_LPAREN);
            iee_pkg::KIND_RPAREN: begin
               forever begin
                  if (otop == 0) begin
                     raise_err(iee_pkg::ST_MALFORMED);
                     return;
                  end
                  if (ops[otop-1] == iee_pkg::OP_LPAREN) begin
                     otop--;
                     break;
                  end
                  if (!reduce()) return;
               end
            end
            default: ;
         endcase
      endfunction

      function void check_result(iee_pkg::rsp_type r);
         iee_pkg::rsp_type e;
         if (pending.size() == 0) begin
            $display("%0t: unexpected result value %0d status %0d",
                     $realtime, r.result_value, r.status);
            failures++;
            return;
         end
         e = pending.pop_front();
         if (r.result_value !== e.result_value) begin
            $display("%0t: result_value expected %0d actual %0d",
                     $realtime, e.result_value, r.result_value);
            failures++;
         end
         if (r.status !== e.status) begin
            $display("%0t: status expected %0d actual %0d", $realtime, e.status, r.status);
            failures++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;
   longint cycles = 0;
   int sent_count = 0;
   bit calm = 0;
   expr_scoreboard sb;

   iee_if #(.payload_type(iee_pkg::req_type)) req_ch (clock);
   iee_if #(.payload_type(iee_pkg::rsp_type)) rsp_ch (clock);

   infix_expression_evaluator u_dut (
      .clock(clock),
      .reset(reset),
      .req(req_ch),
      .rsp(rsp_ch)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Watchdog: a correct run finishes far below this.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // Sample the result channel; values read here are the ones before this edge.
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) sb.check_result(rsp_ch.payload);
   end

   // Build a token; fields the kind does not use carry random bits.
   function automatic iee_pkg::req_type tok(logic [2:0] kind, logic [1:0] code,
                                            logic [30:0] num);
      iee_pkg::req_type t;
      t.token_kind = kind;
      t.operator_code = code;
      t.number_value = num;
      if (kind != iee_pkg::KIND_OPERATOR) t.operator_code = 2'($urandom);
      if (kind != iee_pkg::KIND_NUMBER) t.number_value = 31'($urandom);
      return t;
   endfunction

   // Mostly small magnitudes so products and quotients stay in range, with extremes mixed in.
   function automatic logic [30:0] pick_number();
      case ($urandom_range(0, 7))
         0: return 31'd0;
         1: return 31'h7FFFFFFF;
         2, 3: return 31'($urandom_range(0, 32'h3FFFF));
         4: return 31'($urandom);
         default: return 31'($urandom_range(1, 32'h7FFFF));
      endcase
   endfunction

   // Append a well-formed expression with random nesting.
   function automatic void build_expr(ref iee_pkg::req_type q[$], input int depth);
      int terms;
      terms = $urandom_range(1, 4);
      for (int i = 0; i < terms; i++) begin
         if (i != 0) q.push_back(tok(iee_pkg::KIND_OPERATOR, 2'($urandom), '0));
         if (depth > 0 && $urandom_range(0, 3) == 0) begin
            q.push_back(tok(iee_pkg::KIND_LPAREN, '0, '0));
            build_expr(q, depth - 1);
            q.push_back(tok(iee_pkg::KIND_RPAREN, '0, '0));
         end else
            q.push_back(tok(iee_pkg::KIND_NUMBER, '0, pick_number()));
      end
   endfunction

   // Offer one token and hold it until the block takes it.
   task automatic send_token(iee_pkg::req_type t);
      int gap;
      gap = (!calm && $urandom_range(0, 5) == 0) ? $urandom_range(1, 6) : 0;
      if (gap != 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.payload <= t;
      do @(posedge clock); while (!req_ch.ready);
      sb.note_token(t);
      sent_count++;
   endtask

   task automatic send_all(ref iee_pkg::req_type q[$]);
      foreach (q[i]) send_token(q[i]);
      q.delete();
   endtask

   // Receiver: one long hold-off to back the block up, random short stalls otherwise.
   task automatic drive_ready();
      bit held;
      held = 0;
      forever begin
         if (!held && sent_count >= HOLD_AT) begin
            held = 1;
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else if (!calm && $urandom_range(0, 7) == 0) begin
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end else begin
            rsp_ch.ready <= 1'b1;
            @(posedge clock);
         end
      end
   endtask

   initial begin
      iee_pkg::req_type q[$];
      int pick, n;
      logic [2:0] deep_kind;
      sb = new();
      sb.clear();
      reset <= 1'b1;
      req_ch.valid <= 1'b0;
      req_ch.payload <= '0;
      rsp_ch.ready <= 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      fork
         drive_ready();
      join_none

      // Directed: saturation both ways, divide by zero, unmatched parentheses,
      // empty expression and a leftover value.
      q.push_back(tok(iee_pkg::KIND_NUMBER, '0, 31'h7FFFFFFF));
      q.push_back(tok(iee_pkg::KIND_OPERATOR, iee_pkg::OP_MUL[1:0], '0));
      q.push_back(tok(iee_pkg::KIND_NUMBER, '0, 31'h7FFFFFFF));
      q.push_back(tok(iee_pkg::KIND_END, '0, '0));
      q.push_back(tok(iee_pkg::KIND_NUMBER, '0, 31'd0));
      q.push_back(tok(iee_pkg::KIND_OPERATOR, iee_pkg::OP_SUB[1:0], '0));
      q.push_back(tok(iee_pkg::KIND_NUMBER, '0, 31'h7FFFFFFF));
      q.push_back(tok(iee_pkg::KIND_OPERATOR, iee_pkg::OP_SUB[1:0], '0));
      q.push_back(tok(iee_pkg::KIND_NUMBER, '0, 31'h7FFFFFFF));
      q.push_back(tok(iee_pkg::KIND_END, '0, '0));
      q.push_back(tok(iee_pkg::KIND_NUMBER, '0, 31'h00010000));
      q.push_back(tok(iee_pkg::KIND_OPERATOR, iee_pkg::OP_DIV[1:0], '0));
      q.push_back(tok(iee_pkg::KIND_NUMBER, '0, 31'd0));
      q.push_back(tok(iee_pkg::KIND_END, '0, '0));
      q.push_back(tok(iee_pkg::KIND_RPAREN, '0, '0));
      q.push_back(tok(iee_pkg::KIND_END, '0, '0));
      q.push_back(tok(iee_pkg::KIND_LPAREN, '0, '0));
      q.push_back(tok(iee_pkg::KIND_NUMBER, '0, 31'h00030000));
      q.push_back(tok(iee_pkg::KIND_END, '0, '0));
      q.push_back(tok(iee_pkg::KIND_END, '0, '0));
      q.push_back(tok(iee_pkg::KIND_NUMBER, '0, 31'h00020000));
      q.push_back(tok(iee_pkg::KIND_OPERATOR, iee_pkg::OP_ADD[1:0], '0));
      q.push_back(tok(iee_pkg::KIND_NUMBER, '0, 31'h00018000));
      q.push_back(tok(iee_pkg::KIND_NUMBER, '0, 31'h00004000));
      q.push_back(tok(iee_pkg::KIND_END, '0, '0));
      send_all(q);

      // Random: mostly well-formed expressions, some stack overflow runs and noise.
      while (sent_count < TOKEN_BUDGET) begin
         if (sent_count > TOKEN_BUDGET - 100) calm = 1;
         pick = $urandom_range(0, 19);
         if (pick == 0) begin
            // run one stack past its depth
            deep_kind = $urandom_range(0, 1) ? iee_pkg::KIND_LPAREN : iee_pkg::KIND_NUMBER;
            n = $urandom_range(STACK_N + 1, STACK_N + 4);
            repeat (n) q.push_back(tok(deep_kind, '0, pick_number()));
         end else if (pick <= 2) begin
            n = $urandom_range(1, 6);
            repeat (n) q.push_back(tok(3'($urandom), 2'($urandom), 31'($urandom)));
         end else
            build_expr(q, 3);
         q.push_back(tok(iee_pkg::KIND_END, '0, '0));
         send_all(q);
      end
      req_ch.valid <= 1'b0;

      // Drain, then allow for a final reduction chain full of divisions.
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (2000) @(posedge clock);
      if (sb.failures == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end
endmodule
